// ===== sv/quoted_argument_splitter_defines.svh =====
// ----------------------------------------------------------------------------
// quoted argument splitter assertion macros
// shared concurrent assertion forms for the splitter checks
// ----------------------------------------------------------------------------
`ifndef QUOTED_ARGUMENT_SPLITTER_DEFINES_SVH
`define QUOTED_ARGUMENT_SPLITTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled in reset
`define QAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

// ===== sv/qas_pkg.sv =====
// ----------------------------------------------------------------------------
// qas_pkg
// types, character codes and helpers of the quoted argument splitter
// ----------------------------------------------------------------------------
package qas_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_BARE   = 3'd1,
		PH_QUOTED = 3'd2,
		PH_ESC    = 3'd3,
		PH_HEX    = 3'd4,
		PH_OCT    = 3'd5,
		PH_CLOSED = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_ARG  = 2'd1,
		KIND_DONE = 2'd2,
		KIND_FAIL = 2'd3
	} kind_t;

	// up to two results per request
	typedef struct packed {
		logic [1:0] n;
		kind_t      k0;
		logic [7:0] b0;
		kind_t      k1;
		logic [7:0] b1;
	} res_t;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_EIGHT     = 8'h38;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_A_LC      = 8'h61;
	localparam logic [7:0] CH_B_LC      = 8'h62;
	localparam logic [7:0] CH_F_LC      = 8'h66;
	localparam logic [7:0] CH_N_LC      = 8'h6E;
	localparam logic [7:0] CH_T_LC      = 8'h74;
	localparam logic [7:0] CH_A_UC      = 8'h41;
	localparam logic [7:0] CH_F_UC      = 8'h46;
	localparam logic [7:0] TEN          = 8'h0A;

	function automatic res_t push(res_t r, kind_t k, logic [7:0] b);
		res_t o;
		o = r;
		if (r.n == 2'd0) begin
			o.k0 = k;
			o.b0 = (k == KIND_BYTE) ? b : 8'h00;
		end else begin
			o.k1 = k;
			o.b1 = (k == KIND_BYTE) ? b : 8'h00;
		end
		o.n = r.n + 2'd1;
		return o;
	endfunction

	// {valid, digit value}
	function automatic logic [4:0] hex_val(logic [7:0] b);
		logic [7:0] t;
		t = 8'h00;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			t = b - CH_ZERO;
			return {1'b1, t[3:0]};
		end else if (b >= CH_A_LC && b <= CH_F_LC) begin
			t = b - CH_A_LC + TEN;
			return {1'b1, t[3:0]};
		end else if (b >= CH_A_UC && b <= CH_F_UC) begin
			t = b - CH_A_UC + TEN;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

// ===== sv/quoted_argument_splitter.sv =====
// ----------------------------------------------------------------------------
// quoted_argument_splitter
// splits a command string into arguments and decodes quoted escapes
// ----------------------------------------------------------------------------
// a request passes the input register, then the result register, before its first result
// throughput: 1 request per cycle while the output takes results; a request giving two
//   results holds the result register until both have left, stalling requests with results
// reset: arst_n async low clears phase, escape state, fail flag and valids;
//   the split mode register split_q returns to 1
`include "quoted_argument_splitter_defines.svh"

module quoted_argument_splitter
	import qas_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       split_mode,
	// input requests
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	// results
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] result_kind,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	// configuration register, always writable
	logic split_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			split_q <= split_mode;
		end
	end

	// ------------------------------------------------------------------
	// input register stage
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       advance;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_string;
		end
	end

	// ------------------------------------------------------------------
	// parser state
	// ------------------------------------------------------------------
	phase_t     phase_q;
	logic [8:0] ev_q;       // escape value being built
	logic [1:0] dc_q;       // digits seen in the escape
	logic       failed_q;

	phase_t     ph;
	phase_t     ph_n;
	logic [8:0] ev_n;
	logic [1:0] dc_n;
	logic       fail_n;
	logic       quoted;
	logic [4:0] hv;
	res_t       res;

	// one step of the parser, applied to the held request
	always_comb begin
		ph     = phase_q;
		// split-only phases fall back to outside quotes in unescape mode
		if (!split_q && (ph == PH_BARE || ph == PH_CLOSED)) begin
			ph = PH_IDLE;
		end
		ph_n   = ph;
		ev_n   = ev_q;
		dc_n   = dc_q;
		fail_n = failed_q;
		quoted = 1'b0;
		hv     = hex_val(byte_s1);
		res    = '{n: 2'd0, k0: KIND_BYTE, b0: 8'h00, k1: KIND_BYTE, b1: 8'h00};

		if (eos_s1) begin
			// end of string: report once, then back to reset state
			if (failed_q) begin
				res = push(res, KIND_FAIL, 8'h00);
			end else if (ph == PH_QUOTED || ph == PH_ESC || ph == PH_HEX
					|| ph == PH_OCT) begin
				// unterminated quote or escape
				res = push(res, KIND_FAIL, 8'h00);
			end else begin
				if (ph == PH_BARE || ph == PH_CLOSED) begin
					res = push(res, KIND_ARG, 8'h00);
				end
				res = push(res, KIND_DONE, 8'h00);
			end
			ph_n   = PH_IDLE;
			ev_n   = 9'd0;
			dc_n   = 2'd0;
			fail_n = 1'b0;
		end else if (!failed_q) begin
			case (ph)
				PH_BARE: begin
					if (byte_s1 == CH_SPACE) begin
						res  = push(res, KIND_ARG, 8'h00);
						ph_n = PH_IDLE;
					end else begin
						res = push(res, KIND_BYTE, byte_s1);
					end
				end
				PH_QUOTED: begin
					quoted = 1'b1;
				end
				PH_ESC: begin
					ph_n = PH_QUOTED;
					case (byte_s1)
						CH_A_LC:      res = push(res, KIND_BYTE, 8'h07);
						CH_B_LC:      res = push(res, KIND_BYTE, 8'h08);
						CH_F_LC:      res = push(res, KIND_BYTE, 8'h0C);
						CH_N_LC:      res = push(res, KIND_BYTE, 8'h0A);
						CH_T_LC:      res = push(res, KIND_BYTE, 8'h09);
						CH_BACKSLASH: res = push(res, KIND_BYTE, byte_s1);
						CH_QUOTE:     res = push(res, KIND_BYTE, byte_s1);
						CH_X: begin
							ph_n = PH_HEX;
							ev_n = 9'd0;
							dc_n = 2'd0;
						end
						CH_ZERO: begin
							ph_n = PH_OCT;
							ev_n = 9'd0;
							dc_n = 2'd0;
						end
						default: begin
							// unknown escape
							fail_n = 1'b1;
							ph_n   = PH_IDLE;
						end
					endcase
				end
				PH_HEX: begin
					if (hv[4]) begin
						ev_n = {ev_q[4:0], hv[3:0]};
						dc_n = dc_q + 2'd1;
						if (dc_n >= 2'd2) begin
							res  = push(res, KIND_BYTE, ev_n[7:0]);
							ph_n = PH_QUOTED;
						end
					end else begin
						// short escape closed by a non-digit
						res    = push(res, KIND_BYTE, ev_q[7:0]);
						ph_n   = PH_QUOTED;
						quoted = 1'b1;
					end
				end
				PH_OCT: begin
					if (byte_s1 >= CH_ZERO && byte_s1 < CH_EIGHT) begin
						ev_n = {ev_q[5:0], byte_s1[2:0]};
						dc_n = dc_q + 2'd1;
						if (dc_n >= 2'd3) begin
							res  = push(res, KIND_BYTE, ev_n[7:0]);
							ph_n = PH_QUOTED;
						end
					end else begin
						res    = push(res, KIND_BYTE, ev_q[7:0]);
						ph_n   = PH_QUOTED;
						quoted = 1'b1;
					end
				end
				PH_CLOSED: begin
					// closing quote must be followed by a space
					if (byte_s1 == CH_SPACE) begin
						res  = push(res, KIND_ARG, 8'h00);
						ph_n = PH_IDLE;
					end else begin
						fail_n = 1'b1;
						ph_n   = PH_IDLE;
					end
				end
				default: begin
					ph_n = PH_IDLE;
					if (byte_s1 == CH_QUOTE) begin
						ph_n = PH_QUOTED;
					end else if (split_q && byte_s1 == CH_SPACE) begin
						// skip spaces between arguments
						ph_n = PH_IDLE;
					end else begin
						res = push(res, KIND_BYTE, byte_s1);
						if (split_q) begin
							ph_n = PH_BARE;
						end
					end
				end
			endcase

			// ordinary byte inside quotes
			if (quoted) begin
				if (byte_s1 == CH_QUOTE) begin
					ph_n = split_q ? PH_CLOSED : PH_IDLE;
				end else if (byte_s1 == CH_BACKSLASH) begin
					ph_n = PH_ESC;
				end else begin
					res = push(res, KIND_BYTE, byte_s1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result register: holds the one or two results of a request
	// ------------------------------------------------------------------
	logic       rvalid_q;
	logic [1:0] rn_q;
	logic       ridx_q;
	kind_t      rk0_q;
	kind_t      rk1_q;
	logic [7:0] rb0_q;
	logic [7:0] rb1_q;
	logic       r_last;
	logic       out_free;

	assign r_last   = (rn_q == 2'd1) || ridx_q;
	assign out_free = !rvalid_q || (out_ready && r_last);
	// requests without results never wait on the output side
	assign advance  = valid_s1 && ((res.n == 2'd0) || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			ev_q     <= 9'd0;
			dc_q     <= 2'd0;
			failed_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= ph_n;
			ev_q     <= ev_n;
			dc_q     <= dc_n;
			failed_q <= fail_n;
		end
	end

	// a load only happens when the register is empty or its last result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
			rn_q     <= 2'd0;
			ridx_q   <= 1'b0;
		end else if (advance && res.n != 2'd0) begin
			rvalid_q <= 1'b1;
			rn_q     <= res.n;
			ridx_q   <= 1'b0;
		end else if (rvalid_q && out_ready) begin
			if (r_last) begin
				rvalid_q <= 1'b0;
			end else begin
				ridx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.n != 2'd0) begin
			rk0_q <= res.k0;
			rb0_q <= res.b0;
			rk1_q <= res.k1;
			rb1_q <= res.b1;
		end
	end

	assign out_valid   = rvalid_q;
	assign result_kind = ridx_q ? rk1_q : rk0_q;
	assign out_byte    = ridx_q ? rb1_q : rb0_q;
	assign last_of_run = r_last;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`QAS_ASSERT_NOW(a_res_count, clk, arst_n, rvalid_q, (rn_q == 2'd1) || (rn_q == 2'd2))
	`QAS_ASSERT_NOW(a_load_free, clk, arst_n, advance && (res.n != 2'd0), out_free)
	`QAS_ASSERT_NEXT(a_eos_clear, clk, arst_n, advance && eos_s1,
		(phase_q == PH_IDLE) && !failed_q && (dc_q == 2'd0))
	`QAS_ASSERT_NOW(a_in_open, clk, arst_n, !valid_s1, in_ready)

endmodule
